FILE: sv/ltr_pkg.sv
// ltr_pkg: types and constants shared by the link retry timer engine
// no dependencies; imported by ltr_step, ltr_outq and link_retry_timer_engine
`timescale 1ns / 1ps

package ltr_pkg;

  typedef enum logic [2:0] {
    ACT_INFOACK  = 3'd0,
    ACT_KICK     = 3'd1,
    ACT_ENQUIRY  = 3'd2,
    ACT_CONNREQ  = 3'd3,
    ACT_DISCREQ  = 3'd4,
    ACT_REQUEUE  = 3'd5,
    ACT_TIMEOUT  = 3'd6,
    ACT_DESTROY  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    LINK_IDLE       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_DISCONN    = 2'd2,
    LINK_UP         = 2'd3
  } link_t;

  // condition bit positions
  localparam int unsigned COND_ACK  = 0;
  localparam int unsigned COND_OWN  = 1;
  localparam int unsigned COND_PEER = 2;

  // configuration register indexes
  localparam logic [1:0] REG_RETRANSMIT_RELOAD = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT       = 2'd1;
  localparam logic [1:0] REG_RX_BUFFER_SIZE    = 2'd2;

  // at most three actions per tick
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned Q_DEPTH     = 4;

  typedef struct packed {
    logic        op;
    logic [15:0] rx_mem_used;
    logic        destroy_req;
    logic        listening;
    logic [1:0]  new_link_state;
    logic [2:0]  new_conditions;
    logic [15:0] t1_load;
    logic [15:0] t2_load;
    logic [15:0] t4_load;
    logic        clear_retries;
    logic        new_dead;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic        last;
    logic        notify;
    logic [1:0]  link_state;
    logic [2:0]  conditions;
  } out_item_t;

  typedef struct packed {
    logic [15:0] retransmit_reload;
    logic [4:0]  retry_limit;
    logic [15:0] rx_buffer_size;
  } cfg_t;

  typedef struct packed {
    link_t       link_state;
    logic [2:0]  cond_bits;
    logic [15:0] retransmit_count;
    logic [15:0] ack_delay_count;
    logic [15:0] peer_busy_count;
    logic [4:0]  retry_count;
    logic        dead_flag;
  } link_state_t;

endpackage

FILE: sv/link_retry_timer_engine.sv
// link_retry_timer_engine: timer engine of one link connection
// depends on ltr_pkg, ltr_step, ltr_outq
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_stall   in_item_t (update or tick request)
//   out_*        output     out_valid/out_stall out_item_t (0-3 actions per request)
//   cfg_*        input      cfg_we              cfg_index, cfg_wdata
//
// a request is registered on acceptance and worked from that register once the queue
// has room; its zero to three actions land in a four-entry queue at once and leave
// one per cycle while out_stall is low; a new request can be accepted while the
// actions of earlier ones still wait in the queue
// rst_n (synchronous, active low) clears link state, timers and queue, and loads
// the register defaults 1200, 3 and 32768
// in_stall rises only while a request waits in the input register and the queue
// lacks room for three more actions; out_stall just holds the queue head
`timescale 1ns / 1ps

module link_retry_timer_engine
  import ltr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  cfg_t        cfg_r, cfg_nxt;
  // link state
  link_state_t st_r, st_nxt, st_step;
  // input request register
  in_item_t    req_r;
  logic        req_valid_r, req_valid_nxt;
  // work and queue interface
  out_item_t   res [MAX_RESULTS];
  logic [1:0]  res_n;
  logic        room;
  logic        go;
  logic        in_acc;

  // request is worked once the queue can take a full tick
  assign go       = req_valid_r && room;
  assign in_stall = req_valid_r && !room;
  assign in_acc   = in_valid && !in_stall;
  assign req_valid_nxt = in_acc | (req_valid_r & ~go);
  assign st_nxt   = go ? st_step : st_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RETRANSMIT_RELOAD: cfg_nxt.retransmit_reload = cfg_wdata;
        REG_RETRY_LIMIT:       cfg_nxt.retry_limit       = cfg_wdata[4:0];
        REG_RX_BUFFER_SIZE:    cfg_nxt.rx_buffer_size    = cfg_wdata;
        default:               cfg_nxt = cfg_r;  // unused index is dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retransmit_reload <= 16'd1200;
      cfg_r.retry_limit       <= 5'd3;
      cfg_r.rx_buffer_size    <= 16'd32768;
      st_r                    <= '{link_state: LINK_IDLE, default: '0};
      req_valid_r             <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      req_valid_r <= req_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
  end

  ltr_step u_step (
    .item   (req_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_step),
    .res    (res),
    .res_n  (res_n)
  );

  ltr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (go),
    .push_item (res),
    .push_n    (res_n),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/ltr_step.sv
// ltr_step: combinational work for one request (update or tick)
// depends on ltr_pkg
`timescale 1ns / 1ps

module ltr_step
  import ltr_pkg::*;
(
  input  in_item_t    item,
  input  link_state_t st,
  input  cfg_t        cfg,
  output link_state_t st_nxt,
  output out_item_t   res [MAX_RESULTS],
  output logic [1:0]  res_n
);

  out_item_t   a_item, b_item, c_item;
  logic        a_v, b_v, c_v;
  link_t       ls;
  logic [2:0]  cb;
  logic [15:0] ack_dec, peer_dec, rt_dec;
  logic [15:0] half_buf;

  assign half_buf = cfg.rx_buffer_size >> 1;
  assign ack_dec  = st.ack_delay_count - 16'd1;
  assign peer_dec = st.peer_busy_count - 16'd1;
  assign rt_dec   = st.retransmit_count - 16'd1;

  always_comb begin
    st_nxt = st;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_item = '0;
    b_item = '0;
    c_item = '0;
    ls = st.link_state;
    cb = st.cond_bits;

    if (item.op) begin
      st_nxt.link_state       = link_t'(item.new_link_state);
      st_nxt.cond_bits        = item.new_conditions;
      st_nxt.retransmit_count = item.t1_load;
      st_nxt.ack_delay_count  = item.t2_load;
      st_nxt.peer_busy_count  = item.t4_load;
      st_nxt.dead_flag        = item.new_dead;
      if (item.clear_retries) begin
        st_nxt.retry_count = '0;
      end
    end else if (st.link_state == LINK_IDLE &&
                 (item.destroy_req || (item.listening && st.dead_flag))) begin
      // destroy ends the tick, state untouched
      a_v = 1'b1;
      a_item.action     = ACT_DESTROY;
      a_item.link_state = ls;
      a_item.conditions = cb;
    end else begin
      // release own busy or kick transmit
      if (ls == LINK_UP) begin
        a_v = 1'b1;
        if (item.rx_mem_used < half_buf && cb[COND_OWN]) begin
          cb[COND_OWN] = 1'b0;
          cb[COND_ACK] = 1'b0;
          a_item.action = ACT_INFOACK;
        end else begin
          a_item.action = ACT_KICK;
        end
        a_item.link_state = ls;
        a_item.conditions = cb;
      end

      // ack delay timer
      if (st.ack_delay_count != '0) begin
        st_nxt.ack_delay_count = ack_dec;
        if (ack_dec == '0 && ls == LINK_UP && cb[COND_ACK]) begin
          cb[COND_ACK] = 1'b0;
          b_v = 1'b1;
          b_item.action     = ACT_ENQUIRY;
          b_item.link_state = ls;
          b_item.conditions = cb;
        end
      end

      // peer busy timer
      if (st.peer_busy_count != '0) begin
        st_nxt.peer_busy_count = peer_dec;
        if (peer_dec == '0) begin
          cb[COND_PEER] = 1'b0;
        end
      end

      // retransmit timer
      if (st.retransmit_count != '0) begin
        st_nxt.retransmit_count = rt_dec;
        if (rt_dec == '0) begin
          if (ls != LINK_IDLE) begin
            c_v = 1'b1;
            if (st.retry_count >= cfg.retry_limit) begin
              c_item.notify = ~st.dead_flag;
              c_item.action = ACT_TIMEOUT;
              ls = LINK_IDLE;
              st_nxt.dead_flag = 1'b1;
            end else begin
              st_nxt.retry_count = st.retry_count + 5'd1;
              case (ls)
                LINK_CONNECTING: c_item.action = ACT_CONNREQ;
                LINK_DISCONN:    c_item.action = ACT_DISCREQ;
                default:         c_item.action = ACT_REQUEUE;
              endcase
            end
            c_item.link_state = ls;
            c_item.conditions = cb;
          end
          st_nxt.retransmit_count = cfg.retransmit_reload;
        end
      end

      st_nxt.link_state = ls;
      st_nxt.cond_bits  = cb;
    end

    // pack the actions in order and mark the final one
    if (c_v && !a_v && !b_v) begin
      c_item.last = 1'b1;
    end else if (c_v) begin
      c_item.last = 1'b1;
    end else if (b_v) begin
      b_item.last = 1'b1;
    end else begin
      a_item.last = a_v;
    end
  end

  assign res[0] = a_v ? a_item : (b_v ? b_item : c_item);
  assign res[1] = (a_v && b_v) ? b_item : c_item;
  assign res[2] = c_item;
  assign res_n  = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};

endmodule

FILE: sv/ltr_outq.sv
// ltr_outq: four-entry result queue, up to three pushes and one pop a cycle,
// pops held off by out_stall; depends on ltr_pkg
`timescale 1ns / 1ps

module ltr_outq
  import ltr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  out_item_t  push_item [MAX_RESULTS],
  input  logic [1:0] push_n,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  out_item_t  mem_r [Q_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] n_eff;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // space for a full tick once this cycle's pop is counted
  assign room      = (count_r <= 3'd1) || (count_r == 3'd2 && pop);
  assign n_eff     = push_en ? push_n : 2'd0;

  assign wr_ptr_nxt = wr_ptr_r + n_eff;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, n_eff} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < n_eff) begin
        mem_r[wr_ptr_r + 2'(i)] <= push_item[i];
      end
    end
  end

endmodule
